// ----- rtl/mic_pkg.sv -----
// Shared types and constants for the Mandelbrot checksum core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mic_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DIM    = 256;
  localparam int DEF_ITER_LIMIT = 1023;

  // Decimal fixed point
  localparam int FX_SCALE   = 1000000;
  localparam int CX_OFFSET  = 25 * FX_SCALE / 10;
  localparam int SCALE_MUL  = 35;
  localparam int SCALE_DIV  = 10;
  // 35/10 reduces to 7/2, so the column scale is a multiply and a shift
  localparam int SCALE_GCD   = 5;
  localparam int SCALE_NUM   = SCALE_MUL / SCALE_GCD;
  localparam int SCALE_SHIFT = $clog2(SCALE_DIV / SCALE_GCD);
  localparam logic [47:0] ESC_BOUND = 48'd4000000000000;

  // Division by FX_SCALE: drop its 2^6 factor, multiply by
  // ceil(2^50 / 15625) and keep bits 50 and up; exact below 2^36
  localparam int RCP_PRE    = 6;
  localparam int RCP_SHIFT  = 50;
  localparam int RCP_MUL_W  = 37;
  localparam logic [RCP_MUL_W-1:0] RCP_MUL = 37'd72057594038;
  localparam int RCP_DIG_W  = 12;   // multiplier digit, one per cycle
  localparam int RCP_DIGITS = 3;

  // Datapath widths
  localparam int COORD_W = 24;   // signed orbit and pixel constants
  localparam int NUM_W   = 43;   // dividend magnitude
  localparam int DEN_W   = 20;   // divisor
  localparam int QUO_W   = 22;   // quotient bits, one per divider step
  localparam int CHK_W   = 26;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DIM_CFG_W  = 9;
  localparam int ITER_CFG_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_MAX_ITER = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIXEL,
    ST_COORD,
    ST_MUL,
    ST_TEST,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_sum;
    logic div_coord;
    logic load_cy;
    logic load_cx;
    logic mul;
    logic div_iter;
    logic update;
    logic accum;
    logic next_pixel;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic rcp_done;
    logic cont;
    logic last_pixel;
    logic out_full;
  } ctrl_sts_t;

endpackage

// ----- rtl/mic_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mic_pkg for the operand widths.
`timescale 1ns / 1ps

module mic_div import mic_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  // trial subtraction against the shifted divisor
  always_comb begin
    ge      = (rem_r >= dsh_r);
    rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // operands: divisor starts at its top alignment and walks down
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NUM_W'(den) << (QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/mic_datapath.sv -----
// Datapath: pixel walk, orbit registers, squaring, divider lanes for the
// pixel constants, reciprocal division by the scale, checksum and result
// register. Depends on mic_pkg and mic_div.
`timescale 1ns / 1ps

module mic_datapath import mic_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ITER_LIMIT = DEF_ITER_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DIM_CFG_W-1:0]  width_cfg,
  input  logic [DIM_CFG_W-1:0]  height_cfg,
  input  logic [ITER_CFG_W-1:0] iter_cfg,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CHK_W-1:0]      out_checksum
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int N_W    = $clog2(ITER_LIMIT + 1);
  localparam int P_W    = 2 * COORD_W;
  localparam int RN_W   = RCP_DIGITS * RCP_DIG_W;
  localparam int MAG_W  = RCP_PRE + RN_W;
  localparam int PP_W   = RCP_MUL_W + RCP_DIG_W;
  localparam int ACC_W  = RCP_MUL_W + RN_W;
  localparam int RCNT_W = $clog2(RCP_DIGITS + 1);
  localparam int SCL_W  = QUO_W + 3;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [N_W-1:0]   cap_eff;

  logic [DIM_W-1:0]          x_r, y_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, re_r, im_r;
  logic [N_W-1:0]            n_r;
  logic signed [P_W-1:0]     sq_re_r, sq_im_r, cross_r;
  logic                      neg_a_r, neg_b_r;
  logic [RN_W-1:0]           rn_a_r, rn_b_r;
  logic [ACC_W-1:0]          acc_a_r, acc_b_r;
  logic [RCNT_W-1:0]         rcp_cnt_r;
  logic [CHK_W-1:0]          sum_r;
  logic                      out_valid_r;
  logic [CHK_W-1:0]          out_chk_r;

  logic signed [P_W-1:0]     diff_a, dbl_b;
  logic [MAG_W-1:0]          mag_a, mag_b;
  logic [P_W-1:0]            sq_sum;
  logic [PP_W-1:0]           pp_a, pp_b;
  logic [NUM_W-1:0]          num_a, num_b;
  logic [DEN_W-1:0]          den_a, den_b;
  logic                      done_a, done_b;
  logic [QUO_W-1:0]          quo_a, quo_b;
  logic [SCL_W-1:0]          scl;
  logic signed [COORD_W-1:0] qa_s, qb_s, qa_sgn, qb_sgn;

  // effective dimensions and cap after clamping
  always_comb begin
    if (width_cfg == '0)                w_eff = DIM_W'(1);
    else if (32'(width_cfg) > MAX_DIM)  w_eff = DIM_W'(MAX_DIM);
    else                                w_eff = DIM_W'(width_cfg);
    if (height_cfg == '0)               h_eff = DIM_W'(1);
    else if (32'(height_cfg) > MAX_DIM) h_eff = DIM_W'(MAX_DIM);
    else                                h_eff = DIM_W'(height_cfg);
    if (32'(iter_cfg) > ITER_LIMIT)     cap_eff = N_W'(ITER_LIMIT);
    else                                cap_eff = N_W'(iter_cfg);
  end

  // orbit update terms from the registered products
  always_comb begin
    diff_a = sq_re_r - sq_im_r;
    dbl_b  = cross_r <<< 1;
    mag_a  = MAG_W'(diff_a[P_W-1] ? -diff_a : diff_a);
    mag_b  = MAG_W'(dbl_b[P_W-1] ? -dbl_b : dbl_b);
    sq_sum = $unsigned(sq_re_r) + $unsigned(sq_im_r);
  end

  // reciprocal partial products, top digit first
  always_comb begin
    pp_a = PP_W'(RCP_MUL) * PP_W'(rn_a_r[RN_W-1 -: RCP_DIG_W]);
    pp_b = PP_W'(RCP_MUL) * PP_W'(rn_b_r[RN_W-1 -: RCP_DIG_W]);
  end

  // pixel constant dividends: x*1e6/width and y*1e6/height
  always_comb begin
    num_a = NUM_W'(x_r) * NUM_W'(FX_SCALE);
    den_a = DEN_W'(w_eff);
    num_b = NUM_W'(y_r) * NUM_W'(FX_SCALE);
    den_b = DEN_W'(h_eff);
  end

  mic_div u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_coord),
    .num   (num_a),
    .den   (den_a),
    .done  (done_a),
    .quo   (quo_a)
  );

  mic_div u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_coord),
    .num   (num_b),
    .den   (den_b),
    .done  (done_b),
    .quo   (quo_b)
  );

  // column scale by 35/10 and quotients with the dividend sign restored
  always_comb begin
    scl    = SCL_W'(quo_a) * SCL_W'(SCALE_NUM);
    qa_s   = $signed({2'b00, acc_a_r[RCP_SHIFT+QUO_W-1:RCP_SHIFT]});
    qb_s   = $signed({2'b00, acc_b_r[RCP_SHIFT+QUO_W-1:RCP_SHIFT]});
    qa_sgn = neg_a_r ? -qa_s : qa_s;
    qb_sgn = neg_b_r ? -qb_s : qb_s;
  end

  // reciprocal step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcp_cnt_r <= '0;
    end else if (cmd.div_iter) begin
      rcp_cnt_r <= RCNT_W'(RCP_DIGITS);
    end else if (rcp_cnt_r != '0) begin
      rcp_cnt_r <= rcp_cnt_r - 1'b1;
    end
  end

  // pixel walk and orbit registers
  always_ff @(posedge clk) begin
    if (cmd.clear_sum) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.next_pixel) begin
      if (x_r == w_eff - 1'b1) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
    if (cmd.load_cy) cy_r <= $signed({1'b0, quo_b, 1'b0}) - COORD_W'(FX_SCALE);
    if (cmd.load_cx) begin
      cx_r <= $signed(COORD_W'(scl >> SCALE_SHIFT)) - COORD_W'(CX_OFFSET);
      re_r <= '0;
      im_r <= '0;
      n_r  <= '0;
    end else if (cmd.update) begin
      re_r <= qa_sgn + cx_r;
      im_r <= qb_sgn + cy_r;
      n_r  <= n_r + 1'b1;
    end
    if (cmd.mul) begin
      sq_re_r <= re_r * re_r;
      sq_im_r <= im_r * im_r;
      cross_r <= re_r * im_r;
    end
    // magnitude times reciprocal, one digit per cycle
    if (cmd.div_iter) begin
      neg_a_r <= diff_a[P_W-1];
      neg_b_r <= dbl_b[P_W-1];
      rn_a_r  <= mag_a[MAG_W-1:RCP_PRE];
      rn_b_r  <= mag_b[MAG_W-1:RCP_PRE];
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (rcp_cnt_r != '0) begin
      acc_a_r <= (acc_a_r << RCP_DIG_W) + ACC_W'(pp_a);
      acc_b_r <= (acc_b_r << RCP_DIG_W) + ACC_W'(pp_b);
      rn_a_r  <= rn_a_r << RCP_DIG_W;
      rn_b_r  <= rn_b_r << RCP_DIG_W;
    end
    if (cmd.clear_sum)  sum_r <= '0;
    else if (cmd.accum) sum_r <= sum_r + CHK_W'(n_r);
    if (cmd.emit) out_chk_r <= sum_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.div_done   = done_a & done_b;
    sts.rcp_done   = (rcp_cnt_r == '0);
    sts.cont       = (n_r < cap_eff) && (sq_sum <= ESC_BOUND);
    sts.last_pixel = (x_r == w_eff - 1'b1) && (y_r == h_eff - 1'b1);
    sts.out_full   = out_valid_r && out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_chk_r;

endmodule

// ----- rtl/mic_ctrl.sv -----
// Controller state machine sequencing pixels and escape-time iterations.
// Depends on mic_pkg for the state, command and status types.
`timescale 1ns / 1ps

module mic_ctrl import mic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_start_req,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_start_req) begin
          cmd.clear_sum = 1'b1;
          state_nxt     = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        cmd.div_coord = 1'b1;
        state_nxt     = ST_COORD;
      end
      ST_COORD: begin
        if (sts.div_done) begin
          cmd.load_cy = 1'b1;
          cmd.load_cx = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (sts.cont) begin
          cmd.div_iter = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.accum = 1'b1;
          if (sts.last_pixel) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.next_pixel = 1'b1;
            state_nxt      = ST_PIXEL;
          end
        end
      end
      ST_DIV: begin
        if (sts.rcp_done) begin
          cmd.update = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/mandelbrot_iteration_checksum_core.sv -----
// Escape-time checksum over a pixel grid, decimal fixed point (scale 1e6).
// One start request walks the whole grid row by row; each escape-time
// iteration of a pixel is a multiply, a bound test and a three-digit
// reciprocal division by the scale. Each pixel first forms its constant
// through the 22-step shift-subtract lanes for x/width and y/height, and
// ends with a closing multiply and test. Requests with start_req low are
// taken in idle and give no result. The finished checksum sits in an
// output register, so a new request can be taken while it waits. Depends
// on mic_pkg, mic_ctrl and mic_datapath.
`timescale 1ns / 1ps

module mandelbrot_iteration_checksum_core import mic_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ITER_LIMIT = DEF_ITER_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHK_W-1:0]      out_checksum,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_CFG_W-1:0]  width_r, height_r;
  logic [ITER_CFG_W-1:0] iter_r;
  ctrl_cmd_t             cmd;
  ctrl_sts_t             sts;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_CFG_W'(128);
      height_r <= DIM_CFG_W'(128);
      iter_r   <= ITER_CFG_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:    width_r  <= cfg_data[DIM_CFG_W-1:0];
        CFG_HEIGHT:   height_r <= cfg_data[DIM_CFG_W-1:0];
        CFG_MAX_ITER: iter_r   <= cfg_data[ITER_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  mic_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mic_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ITER_LIMIT (ITER_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .width_cfg    (width_r),
    .height_cfg   (height_r),
    .iter_cfg     (iter_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_checksum (out_checksum)
  );

endmodule

// ----- rtl/mic_checker.sv -----
// Port-level checks for the checksum core, attached by bind.
// Depends on mic_pkg and the top-level port list.
`timescale 1ns / 1ps

module mic_checker import mic_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_start_req,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CHK_W-1:0] out_checksum
);

  // a held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_checksum))
    else $error("result changed while stalled");

  // a start request makes the block busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_start_req |=> in_stall)
    else $error("start request did not make the block busy");

  // a new result only comes out of a running computation
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind mandelbrot_iteration_checksum_core mic_checker u_mic_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking bench for the Mandelbrot escape-time checksum core.
// Directed table plus randomised phases on small grids, with a built-in
// fixed-point predictor. Depends on mic_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import mic_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3; // no such register
  localparam int SETTLE = 200;  // cycles for an idle request to clear

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   start;
    logic                   fixed;     // expected value typed in below
    logic [CHK_W-1:0]       checksum;
  } stim_row_t;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_stall;
  logic                  in_start_req = 0;
  logic                  out_valid;
  logic                  out_stall = 0;
  logic [CHK_W-1:0]      out_checksum;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the register file
  logic [DIM_CFG_W-1:0]  grid_w = 9'd128;
  logic [DIM_CFG_W-1:0]  grid_h = 9'd128;
  logic [ITER_CFG_W-1:0] iter_cap = 10'd100;

  logic [CHK_W-1:0] sums_due[$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  mandelbrot_iteration_checksum_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_start_req(in_start_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_checksum(out_checksum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Escape-time sum over the whole grid
  function automatic logic [CHK_W-1:0] grid_checksum(
      input logic [DIM_CFG_W-1:0] wr, input logic [DIM_CFG_W-1:0] hr,
      input logic [ITER_CFG_W-1:0] cr);
    longint w, h, cap, re, im, nre, n, cx, cy, sum;
    longint x, y;
    w = (wr == 0) ? 1 : ((wr > DEF_MAX_DIM) ? DEF_MAX_DIM : wr);
    h = (hr == 0) ? 1 : ((hr > DEF_MAX_DIM) ? DEF_MAX_DIM : hr);
    cap = (cr > DEF_ITER_LIMIT) ? DEF_ITER_LIMIT : cr;
    sum = 0;
    for (y = 0; y < h; y++) begin
      cy = (y * FX_SCALE / h) * 2 - FX_SCALE;
      for (x = 0; x < w; x++) begin
        cx = (x * FX_SCALE / w) * SCALE_MUL / SCALE_DIV - CX_OFFSET;
        re = 0; im = 0; n = 0;
        while (n < cap && re * re + im * im <= longint'(ESC_BOUND)) begin
          nre = (re * re - im * im) / FX_SCALE + cx;
          im = (2 * re * im) / FX_SCALE + cy;
          re = nre;
          n++;
        end
        sum += n;
      end
    end
    return sum[CHK_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Offer one request; returns at the edge that took it
  task automatic send_request(input logic start, input logic fixed,
                              input logic [CHK_W-1:0] typed);
    bit ok;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_start_req <= start;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (start)
      sums_due.push_back(fixed ? typed : grid_checksum(grid_w, grid_h, iter_cap));
  endtask

  // Register write, only once the core has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit ok;
    in_valid <= 0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 0;
    case (idx)
      CFG_WIDTH:    grid_w = data[DIM_CFG_W-1:0];
      CFG_HEIGHT:   grid_h = data[DIM_CFG_W-1:0];
      CFG_MAX_ITER: iter_cap = data[ITER_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Result side back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 20000;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Result check: stable at the falling edge, taken at the next rising one
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected checksum %0d", out_checksum));
      end else begin
        if (out_checksum !== sums_due[0])
          report_mismatch($sformatf("checksum %0d, wanted %0d",
                                    out_checksum, sums_due[0]));
        void'(sums_due.pop_front());
      end
    end
  end

  localparam int N_ROWS = 25;
  stim_row_t plan [N_ROWS] = '{
    '{ROW_CFG, CFG_WIDTH,    10'd1,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_HEIGHT,   10'd1,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_MAX_ITER, 10'd0,    1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b1, 26'd0},   // zero cap
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b0, 1'b0, 26'd0},   // no request
    '{ROW_CFG, CFG_MAX_ITER, 10'd1,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_WIDTH,    10'd511,  1'b0, 1'b0, 26'd0},   // saturates
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b1, 26'd256},
    '{ROW_CFG, CFG_WIDTH,    10'd0,    1'b0, 1'b0, 26'd0},   // read as 1
    '{ROW_CFG, CFG_HEIGHT,   10'd3,    1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b1, 26'd3},
    '{ROW_CFG, CFG_HEIGHT,   10'd256,  1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b1, 26'd256},
    '{ROW_CFG, CFG_HEIGHT,   10'd1,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_WIDTH,    10'd2,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_MAX_ITER, 10'd1023, 1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b0, 26'd0},
    '{ROW_CFG, CFG_UNUSED,   10'd1023, 1'b0, 1'b0, 26'd0},   // ignored
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b0, 26'd0},
    '{ROW_CFG, CFG_WIDTH,    10'h203,  1'b0, 1'b0, 26'd0},   // top bit dropped
    '{ROW_CFG, CFG_HEIGHT,   10'd2,    1'b0, 1'b0, 26'd0},
    '{ROW_CFG, CFG_MAX_ITER, 10'd20,   1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b0, 1'b0, 26'd0},
    '{ROW_REQ, CFG_WIDTH,    10'd0,    1'b1, 1'b0, 26'd0}
  };

  // Main stimulus
  initial begin
    int idle_set [4] = '{0, 85, 0, 17};
    int stall_set [4] = '{0, 0, 85, 17};
    int wv;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].idx, plan[i].data);
      else
        send_request(plan[i].start, plan[i].fixed, plan[i].checksum);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wv = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
      write_reg(CFG_WIDTH, CFG_DATA_W'(wv));
      write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(4, 1)));
      write_reg(CFG_MAX_ITER, CFG_DATA_W'($urandom_range(30)));
      in_idle_pct = idle_set[ph];
      out_stall_pct = stall_set[ph];
      // long hold-off on the result side while requests keep coming
      if (ph == 0) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < 25; k++)
        send_request($urandom_range(9) < 7, 1'b0, '0);
    end
    in_valid <= 0;

    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
